[hw/rtl/mef_pkg.sv]
// Package for the majority element finder: sizes, word types, engine
// control structs and sequencer codes. No dependencies.
`default_nettype none

package mef_pkg;

    localparam int MAX_LEN    = 256;
    localparam int SYM_W      = 8;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int PAIR_DEPTH = MAX_LEN / 2;
    localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int PAIR_CW    = $clog2(PAIR_DEPTH + 1);

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic go;
        t_len len;
        logic ovf;
    } t_start;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
        t_sym cand;
        logic ovf;
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LEVEL = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        K_FETCH  = 2'd0,
        K_COUNT  = 2'd1,
        K_PAIR   = 2'd2,
        K_VERIFY = 2'd3
    } t_kind;

endpackage

`default_nettype wire

[hw/rtl/mef_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mef_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mef_engine.sv]
// Pair reduction and verification sequencer. Walks the sequence and pair
// memories through their read ports and writes kept pairs back. Uses mef_pkg.
`default_nettype none

module mef_engine
    import mef_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_start              i_start,
    input  wire logic                i_take,
    output t_status                  o_status,
    output logic                     o_seq_re,
    output logic [ADDR_W-1:0]        o_seq_raddr,
    input  wire t_sym                i_seq_rdata,
    output logic                     o_pair_we,
    output logic [PAIR_AW-1:0]       o_pair_waddr,
    output t_sym                     o_pair_wdata,
    output logic                     o_pair_re,
    output logic [PAIR_AW-1:0]       o_pair_raddr,
    input  wire t_sym                i_pair_rdata
);

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic               r_src, n_src;
    t_len               r_n, n_n;
    t_len               r_len, n_len;
    logic               r_ovf, n_ovf;
    t_len               r_addr, n_addr;
    t_len               r_lim, n_lim;
    t_len               r_cnt, n_cnt;
    logic [PAIR_CW-1:0] r_j, n_j;
    logic               r_rd_vld, n_rd_vld;
    logic               r_rd_odd, n_rd_odd;
    t_sym               r_cand, n_cand;
    t_sym               r_prev, n_prev;
    logic               r_found, n_found;

    logic issue;
    t_sym rd_data;
    logic pair_we;

    assign issue   = (r_state == S_SCAN) && (r_addr < r_lim);
    assign rd_data = r_src ? i_pair_rdata : i_seq_rdata;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_src    = r_src;
        n_n      = r_n;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_addr   = r_addr;
        n_lim    = r_lim;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_cand   = r_cand;
        n_prev   = r_prev;
        n_found  = r_found;
        n_rd_vld = issue;
        n_rd_odd = r_addr[0];
        pair_we  = 1'b0;

        if (issue) begin
            n_addr = r_addr + LEN_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_len   = i_start.len;
                    n_ovf   = i_start.ovf;
                    n_n     = i_start.len;
                    n_src   = 1'b0;
                    n_state = S_LEVEL;
                end
            end
            S_LEVEL: begin
                n_addr = '0;
                n_cnt  = '0;
                n_j    = '0;
                if (r_n == '0) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else if (r_n == LEN_W'(1)) begin
                    n_kind  = K_FETCH;
                    n_lim   = LEN_W'(1);
                    n_state = S_SCAN;
                end else if (r_n[0]) begin
                    n_kind  = K_FETCH;
                    n_addr  = r_n - LEN_W'(1);
                    n_lim   = r_n;
                    n_state = S_SCAN;
                end else begin
                    n_kind  = K_PAIR;
                    n_lim   = r_n;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_vld) begin
                    unique case (r_kind)
                        K_FETCH: n_cand = rd_data;
                        K_COUNT, K_VERIFY: begin
                            if (rd_data == r_cand) begin
                                n_cnt = r_cnt + LEN_W'(1);
                            end
                        end
                        K_PAIR: begin
                            if (!r_rd_odd) begin
                                n_prev = rd_data;
                            end else if (rd_data == r_prev) begin
                                pair_we = 1'b1;
                                n_j     = r_j + PAIR_CW'(1);
                            end
                        end
                        default: n_cand = r_cand;
                    endcase
                end
                if (!issue && !r_rd_vld) begin
                    unique case (r_kind)
                        K_FETCH: begin
                            n_addr = '0;
                            n_cnt  = '0;
                            if (r_n == LEN_W'(1)) begin
                                n_kind = K_VERIFY;
                                n_src  = 1'b0;
                                n_lim  = r_len;
                            end else begin
                                n_kind = K_COUNT;
                                n_lim  = r_n;
                            end
                        end
                        K_COUNT: begin
                            n_addr = '0;
                            n_cnt  = '0;
                            if (r_cnt > {1'b0, r_n[LEN_W-1:1]}) begin
                                n_kind = K_VERIFY;
                                n_src  = 1'b0;
                                n_lim  = r_len;
                            end else begin
                                n_kind = K_PAIR;
                                n_n    = r_n - LEN_W'(1);
                                n_lim  = r_n - LEN_W'(1);
                                n_j    = '0;
                            end
                        end
                        K_PAIR: begin
                            n_n     = LEN_W'(r_j);
                            n_src   = 1'b1;
                            n_state = S_LEVEL;
                        end
                        K_VERIFY: begin
                            n_found = r_cnt > {1'b0, r_len[LEN_W-1:1]};
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_src    <= n_src;
        r_n      <= n_n;
        r_len    <= n_len;
        r_ovf    <= n_ovf;
        r_addr   <= n_addr;
        r_lim    <= n_lim;
        r_cnt    <= n_cnt;
        r_j      <= n_j;
        r_rd_odd <= n_rd_odd;
        r_cand   <= n_cand;
        r_prev   <= n_prev;
        r_found  <= n_found;
    end

    assign o_seq_re     = issue && !r_src;
    assign o_seq_raddr  = r_addr[ADDR_W-1:0];
    assign o_pair_re    = issue && r_src;
    assign o_pair_raddr = r_addr[PAIR_AW-1:0];
    assign o_pair_we    = pair_we;
    assign o_pair_waddr = r_j[PAIR_AW-1:0];
    assign o_pair_wdata = rd_data;

    assign o_status.busy  = (r_state != S_IDLE);
    assign o_status.done  = (r_state == S_DONE);
    assign o_status.found = r_found;
    assign o_status.cand  = r_cand;
    assign o_status.ovf   = r_ovf;

endmodule

`default_nettype wire

[hw/rtl/majority_element_finder.sv]
// After the last word the stored words are reduced and the result follows,
// set by one memory read a cycle.
// Throughput: one word per cycle while loading; none while reducing or holding a result.
// Reset: synchronous, active low; clears length, overflow mark, sequencer and output valid.
// Top level: load path, output register; uses mef_pkg, mef_ram, mef_engine.
`default_nettype none

module majority_element_finder
    import mef_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_stall,
    input  wire t_sym   i_symbol,
    input  wire logic   i_is_last,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic        o_found,
    output t_sym        o_majority_symbol,
    output logic        o_overflowed
);

    t_len    r_len, n_len;
    logic    r_ovf, n_ovf;
    logic    r_out_valid, n_out_valid;
    logic    r_found;
    t_sym    r_sym;
    logic    r_out_ovf;

    t_start  start;
    t_status status;
    logic    acc;
    logic    full;
    logic    out_free;
    logic    take;

    logic                 seq_re;
    logic [ADDR_W-1:0]    seq_raddr;
    t_sym                 seq_rdata;
    logic                 pair_we;
    logic [PAIR_AW-1:0]   pair_waddr;
    t_sym                 pair_wdata;
    logic                 pair_re;
    logic [PAIR_AW-1:0]   pair_raddr;
    t_sym                 pair_rdata;

    assign o_stall  = status.busy;
    assign acc      = i_valid && !o_stall;
    assign full     = (r_len == LEN_W'(MAX_LEN));
    assign out_free = !r_out_valid || !i_stall;
    assign take     = status.done && out_free;

    assign start.go  = acc && i_is_last;
    assign start.len = full ? r_len : r_len + LEN_W'(1);
    assign start.ovf = r_ovf || full;

    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        if (acc) begin
            if (i_is_last) begin
                n_len = '0;
                n_ovf = 1'b0;
            end else if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
        end
        if (out_free) begin
            n_out_valid = status.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_found   <= status.found;
            r_sym     <= status.found ? status.cand : '0;
            r_out_ovf <= status.ovf;
        end
    end

    mef_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (SYM_W),
        .AW    (ADDR_W)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (acc && !full),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (i_symbol),
        .i_re    (seq_re),
        .i_raddr (seq_raddr),
        .o_rdata (seq_rdata)
    );

    mef_ram #(
        .DEPTH (PAIR_DEPTH),
        .WIDTH (SYM_W),
        .AW    (PAIR_AW)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_re    (pair_re),
        .i_raddr (pair_raddr),
        .o_rdata (pair_rdata)
    );

    mef_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_take       (take),
        .o_status     (status),
        .o_seq_re     (seq_re),
        .o_seq_raddr  (seq_raddr),
        .i_seq_rdata  (seq_rdata),
        .o_pair_we    (pair_we),
        .o_pair_waddr (pair_waddr),
        .o_pair_wdata (pair_wdata),
        .o_pair_re    (pair_re),
        .o_pair_raddr (pair_raddr),
        .i_pair_rdata (pair_rdata)
    );

    assign o_valid           = r_out_valid;
    assign o_found           = r_found;
    assign o_majority_symbol = r_sym;
    assign o_overflowed      = r_out_ovf;

endmodule

`default_nettype wire

[hw/rtl/mef_checker.sv]
// Port-level checker for majority_element_finder, attached by bind.
// Uses mef_pkg.
`default_nettype none

module mef_checker
    import mef_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire t_sym i_symbol,
    input wire logic i_is_last,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_found,
    input wire t_sym o_majority_symbol,
    input wire logic o_overflowed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found)
            && $stable(o_majority_symbol) && $stable(o_overflowed))
        else $error("result word changed while stalled");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_majority_symbol == '0)
        else $error("symbol not zero without majority");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_last |=> o_stall)
        else $error("input not stalled after last word");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind majority_element_finder mef_checker u_mef_checker (.*);

`default_nettype wire
